/* rtl/ulsan_pkg.sv */
// shared types, constants and byte classification for the utf-8 sanitizer
package ulsan_pkg;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [7:0] CONT_LO = 8'h80;
	localparam logic [7:0] CONT_HI = 8'hBF;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] E0_LO = 8'hA0;
	localparam logic [7:0] ED_HI = 8'h9F;
	localparam logic [7:0] F0_LO = 8'h90;
	localparam logic [7:0] F4_HI = 8'h8F;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEAD,
		ST_FOLLOW,
		ST_REPL,
		ST_SEQ
	} state_t;

	// request to the shared follow-byte range checker
	typedef struct packed {
		logic [7:0] lead;
		logic [2:0] off;
		logic [7:0] data;
	} chk_req_t;

	// sequence length of a lead byte, zero for a byte that cannot lead
	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] len;
		if (c < CONT_LO) begin
			len = 3'd1;
		end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
			len = 3'd2;
		end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
			len = 3'd3;
		end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage

/* rtl/ulsan_follow_chk.sv */
// shared range compare unit: is a byte acceptable at an offset after a lead
module ulsan_follow_chk (
	input  ulsan_pkg::chk_req_t req,
	output logic                ok
);
	import ulsan_pkg::*;

	logic [7:0] lo;
	logic [7:0] hi;

	// tightened bounds apply only to the byte right after the lead
	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (req.off == 3'd1) begin
			if (req.lead == LEAD3_LO) begin
				lo = E0_LO;
			end else if (req.lead == LEAD_ED) begin
				hi = ED_HI;
			end else if (req.lead == LEAD4_LO) begin
				lo = F0_LO;
			end else if (req.lead == LEAD4_HI) begin
				hi = F4_HI;
			end
		end
		ok = (req.data >= lo) && (req.data <= hi);
	end

endmodule

/* rtl/utf8_lossy_sanitizer.sv */
// utf-8 sanitizer top level: byte buffer, scan sequencer and output beats
// order: the byte is taken, then each scan step passes the lead state, the follow check for up to
// three follow bytes (one byte per cycle through the shared range checker) and the output
// beats; a last lead state finds the buffer empty
// throughput: one item at a time, in_stall high from the accept edge until idle again
// reset: arst_n clears the held count and the sequencer; no clearing pass
module utf8_lossy_sanitizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import ulsan_pkg::*;

	state_t     state_q, state_d;
	logic [7:0] buf_q [4];
	logic [2:0] n_q;
	logic       last_q;
	logic [2:0] k_q;
	logic [1:0] idx_q;
	logic [2:0] rem_q;

	logic       in_acc, out_acc;
	logic [2:0] llen, need, avail;
	logic       chk_done, chk_ok, shift;
	chk_req_t   req;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// lead classification of the buffer head
	assign llen  = lead_len(buf_q[0]);
	assign need  = llen - 3'd1;
	assign avail = n_q - 3'd1;
	assign chk_done = (k_q > need) || (k_q > avail);

	// one follow byte per cycle through the shared checker
	assign req.lead = buf_q[0];
	assign req.off  = k_q;
	assign req.data = buf_q[k_q[1:0]];

	ulsan_follow_chk u_chk (
		.req (req),
		.ok  (chk_ok)
	);

	// handshake and output beat
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_REPL) || (state_q == ST_SEQ);
	assign shift     = out_acc && ((state_q == ST_SEQ) || (idx_q == 2'd2));

	always_comb begin
		out_byte = buf_q[0];
		out_last = 1'b0;
		if (state_q == ST_REPL) begin
			unique case (idx_q)
				2'd0: out_byte = REPL_B0;
				2'd1: out_byte = REPL_B1;
				default: out_byte = REPL_B2;
			endcase
			out_last = last_q && (n_q == 3'd1) && (idx_q == 2'd2);
		end else if (state_q == ST_SEQ) begin
			out_last = last_q && (n_q == 3'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_LEAD;
			end
			ST_LEAD: begin
				if (n_q == 3'd0) state_d = ST_IDLE;
				else if (llen == 3'd1) state_d = ST_SEQ;
				else if (llen == 3'd0) state_d = ST_REPL;
				else state_d = ST_FOLLOW;
			end
			ST_FOLLOW: begin
				if (chk_done) begin
					if (avail >= need) state_d = ST_SEQ;
					else if (last_q) state_d = ST_REPL;
					else state_d = ST_IDLE;
				end else if (!chk_ok) begin
					state_d = ST_REPL;
				end
			end
			ST_REPL: begin
				if (out_acc && idx_q == 2'd2) state_d = ST_LEAD;
			end
			ST_SEQ: begin
				if (out_acc && rem_q == 3'd1) state_d = ST_LEAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= 3'd0;
			last_q  <= 1'b0;
			k_q     <= 3'd1;
			idx_q   <= 2'd0;
			rem_q   <= 3'd1;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				n_q    <= n_q + 3'd1;
				last_q <= in_last;
			end else if (shift) begin
				n_q <= n_q - 3'd1;
			end
			if (state_q == ST_LEAD) begin
				k_q   <= 3'd1;
				idx_q <= 2'd0;
				rem_q <= 3'd1;
			end
			if (state_q == ST_FOLLOW) begin
				if (chk_done) rem_q <= llen;
				else if (chk_ok) k_q <= k_q + 3'd1;
			end
			if (state_q == ST_REPL && out_acc) idx_q <= idx_q + 2'd1;
			if (state_q == ST_SEQ && out_acc) rem_q <= rem_q - 3'd1;
		end
	end

	// byte buffer: append at the fill point, drop the head after its last beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q[n_q[1:0]] <= in_byte;
		end else if (shift) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
	end

	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (n_q <= 3'd3))
		else $error("more than three bytes held between items");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (n_q != 3'd0))
		else $error("output beat with an empty buffer");

	a_follow_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLLOW) |-> (k_q >= 3'd1 && n_q >= 3'd1 && llen >= 3'd2))
		else $error("follow check outside a multi-byte lead");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_last) |=> (n_q == 3'd0))
		else $error("buffer not empty after final beat");

endmodule

/* bench/utf8_lossy_sanitizer_chk.sv */
// checker for the utf-8 sanitizer: predicts output beats per input beat and compares them
module utf8_lossy_sanitizer_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       out_last,
	output int         fails,
	output int         pending
);
	import ulsan_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} san_beat_t;

	san_beat_t  san_q[$];
	logic [7:0] hold_b [3];
	int         hold_n;
	int         fail_n;
	int         beat_n;

	initial begin
		fails = 0;
		pending = 0;
	end

	// length of a sequence started by c, zero when c cannot lead
	function automatic int seq_len(input logic [7:0] c);
		if (c < CONT_LO) return 1;
		if (c >= LEAD2_LO && c <= LEAD2_HI) return 2;
		if (c >= LEAD3_LO && c <= LEAD3_HI) return 3;
		if (c >= LEAD4_LO && c <= LEAD4_HI) return 4;
		return 0;
	endfunction

	// range check of the byte at offset k behind lead c
	function automatic bit follow_fits(input logic [7:0] c, input int k, input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (k == 1) begin
			if (c == LEAD3_LO) lo = E0_LO;
			else if (c == LEAD_ED) hi = ED_HI;
			else if (c == LEAD4_LO) lo = F0_LO;
			else if (c == LEAD4_HI) hi = F4_HI;
		end
		return (b >= lo) && (b <= hi);
	endfunction

	function automatic void push_repl();
		san_q.push_back('{data: REPL_B0, last: 1'b0});
		san_q.push_back('{data: REPL_B1, last: 1'b0});
		san_q.push_back('{data: REPL_B2, last: 1'b0});
	endfunction

	// scan held bytes plus the new one and queue the sanitized beats
	task automatic predict_beat(input logic [7:0] b, input logic l);
		logic [7:0] scan_b [4];
		int         n;
		int         pos;
		int         len;
		int         avail;
		int         need;
		int         made;
		int         k;
		bit         ok;
		n = hold_n;
		pos = 0;
		made = san_q.size();
		for (k = 0; k < n; k++) scan_b[k] = hold_b[k];
		scan_b[n] = b;
		n++;
		while (pos < n) begin
			len = seq_len(scan_b[pos]);
			if (len == 1) begin
				san_q.push_back('{data: scan_b[pos], last: 1'b0});
				pos++;
			end else if (len == 0) begin
				push_repl();
				pos++;
			end else begin
				avail = n - pos - 1;
				need = len - 1;
				ok = 1'b1;
				for (k = 1; k <= need && k <= avail && ok; k++) begin
					if (!follow_fits(scan_b[pos], k, scan_b[pos + k])) ok = 1'b0;
				end
				if (!ok) begin
					push_repl();
					pos++;
				end else if (avail >= need) begin
					for (k = 0; k < len; k++) san_q.push_back('{data: scan_b[pos + k], last: 1'b0});
					pos += len;
				end else if (l) begin
					push_repl();
					pos++;
				end else begin
					break;
				end
			end
		end
		hold_n = 0;
		for (k = 0; k < 3; k++) hold_b[k] = 8'h00;
		while (pos + hold_n < n && hold_n < 3) begin
			hold_b[hold_n] = scan_b[pos + hold_n];
			hold_n++;
		end
		if (l && san_q.size() > made) san_q[san_q.size() - 1].last = 1'b1;
	endtask

	// compare accepted output beats first, then predict from the accepted input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			san_q.delete();
			hold_n = 0;
			for (int i = 0; i < 3; i++) hold_b[i] = 8'h00;
			fail_n = 0;
			beat_n = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (san_q.size() == 0) begin
					fail_n++;
					if (fail_n <= 10)
						$display("out beat %0d: none expected, got byte %02h last %0b",
							beat_n, out_byte, out_last);
				end else begin
					if (out_byte !== san_q[0].data || out_last !== san_q[0].last) begin
						fail_n++;
						if (fail_n <= 10)
							$display("out beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
								beat_n, san_q[0].data, san_q[0].last, out_byte, out_last);
					end
					void'(san_q.pop_front());
				end
				beat_n++;
			end
			if (in_valid && !in_stall) predict_beat(in_byte, in_last);
		end
		fails <= fail_n;
		pending <= san_q.size();
	end

endmodule

/* bench/tb_utf8_lossy_sanitizer.sv */
// testbench top for the utf-8 sanitizer: reset, byte stimulus, back-pressure and verdict
module tb_utf8_lossy_sanitizer;
	import ulsan_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 75;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	int         fails;
	int         pending;
	int         stall_pct = 0;
	int         send_idle_pct;
	int         quiet_cycles;
	logic [8:0] text_q[$];

	utf8_lossy_sanitizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	utf8_lossy_sanitizer_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("utf8_lossy_sanitizer: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [8:0] item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= item[7:0];
		in_last <= item[8];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold the sender until every predicted beat has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// queue one random sequence: mostly well-formed, some broken, some noise
	task automatic add_random_seq();
		logic [7:0] seq_b [4];
		logic [7:0] lo;
		logic [7:0] hi;
		int         kind;
		int         len;
		int         cut;
		kind = $urandom_range(99);
		if (kind < 25) begin
			seq_b[0] = 8'($urandom_range(8'h7F));
			len = 1;
		end else if (kind < 80) begin
			len = $urandom_range(2, 4);
			lo = CONT_LO;
			hi = CONT_HI;
			if (len == 2) begin
				seq_b[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
			end else if (len == 3) begin
				seq_b[0] = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
				if (seq_b[0] == LEAD3_LO) lo = E0_LO;
				if (seq_b[0] == LEAD_ED) hi = ED_HI;
			end else begin
				seq_b[0] = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
				if (seq_b[0] == LEAD4_LO) lo = F0_LO;
				if (seq_b[0] == LEAD4_HI) hi = F4_HI;
			end
			seq_b[1] = 8'($urandom_range(lo, hi));
			for (int k = 2; k < len; k++) seq_b[k] = 8'($urandom_range(CONT_LO, CONT_HI));
			// broken sequence: cut short, or cut short and ended with a random byte
			if (kind >= 68) begin
				cut = $urandom_range(1, len - 1);
				if ($urandom_range(1)) begin
					seq_b[cut] = 8'($urandom_range(8'hFF));
					len = cut + 1;
				end else begin
					len = cut;
				end
			end
		end else begin
			seq_b[0] = 8'($urandom_range(8'hFF));
			len = 1;
		end
		for (int k = 0; k < len; k++) text_q.push_back({1'b0, seq_b[k]});
		if ($urandom_range(99) < 12) text_q[text_q.size() - 1][8] = 1'b1;
	endtask

	initial begin
		int sent;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		in_last <= 1'b0;
		send_idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero byte, range edges of two-byte leads and of E0, ED, F0 and F4, bad second bytes,
		// invalid leads, stray continuation, truncation at the last byte
		text_q = '{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0DF, 9'h0BF,
			9'h0E0, 9'h0A0, 9'h080, 9'h0ED, 9'h09F, 9'h0BF,
			9'h0F0, 9'h090, 9'h080, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
			9'h0E0, 9'h09F, 9'h0F4, 9'h090, 9'h0FF, 9'h0C1, 9'h0E1, 9'h180};

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 19;
					stall_pct <= 80;
				end
				1: begin
					send_idle_pct = 80;
					stall_pct <= 19;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS || text_q.size() != 0) begin
				if (text_q.size() == 0) add_random_seq();
				send_beat(text_q.pop_front());
				sent++;
			end
			wait_drained();
		end

		// trailing cycles catch any beat the block still emits
		repeat (40) @(posedge clk);
		if (fails == 0) begin
			$display("utf8_lossy_sanitizer: match");
		end else begin
			$display("utf8_lossy_sanitizer: mismatch");
		end
		$finish;
	end

endmodule
